// ===== hdl/lcq_pkg.sv =====
// lcq_pkg: shared types and constants for the linear or circular queue unit
// no dependencies

package lcq_pkg;

  localparam int LIMIT_W = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic MODE_RESET = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_DISPLAY = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_DISPLAY,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELETE,
    ST_DISPLAY
  } state_t;

  typedef struct packed {
    logic circular_mode;
    logic [LIMIT_W-1:0] queue_limit;
  } cfg_t;

endpackage

// ===== hdl/linear_or_circular_queue_unit.sv =====
// linear_or_circular_queue_unit: top level with stream ports and register port
// depends on lcq_pkg, lcq_front, lcq_back
//
// Array queue of DEPTH words, linear or circular by the mode register, limited to
// queue_limit entries. Commands enter a two-entry queue and run one at a time.
// Insert, an unused func code, or delete and display on an empty queue load their
// result from the idle state. Delete and display read the store through its
// registered read port and load from their own state, display once per element shown.
// The result register holds one transaction; commands wait while it holds one not taken.

module linear_or_circular_queue_unit import lcq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // data_in
  input  logic [1:0]                             s_tuser,  // func
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((DATA_WIDTH + 9) / 8) * 8 - 1:0] m_tdata,  // data_out, is_empty, is_full
  output logic [1:0]                             m_tuser,  // status
  output logic                                   m_tlast,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [APB_ADDR_W-1:0]                  paddr,
  input  logic [APB_DATA_W-1:0]                  pwdata,
  output logic [APB_DATA_W-1:0]                  prdata,
  output logic                                   pready
);

  localparam int OUT_TW = ((DATA_WIDTH + 9) / 8) * 8;

  cfg_t                  cfg;
  logic                  cmd_valid;
  logic                  cmd_ready;
  op_t                   cmd_op;
  logic [DATA_WIDTH-1:0] cmd_data;
  logic [DATA_WIDTH-1:0] out_data;
  logic                  out_empty;
  logic                  out_full;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.circular_mode <= MODE_RESET;
      cfg.queue_limit   <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MODE:  cfg.circular_mode <= pwdata[0];
        REG_LIMIT: cfg.queue_limit   <= pwdata[LIMIT_W-1:0];
        default:   cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = {{(APB_DATA_W - 1){1'b0}}, cfg.circular_mode};
      REG_LIMIT: prdata = {{(APB_DATA_W - LIMIT_W){1'b0}}, cfg.queue_limit};
      default:   prdata = '0;
    endcase
  end

  lcq_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_data   (s_tdata[DATA_WIDTH-1:0]),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd_op),
    .cmd_data  (cmd_data)
  );

  lcq_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd_op),
    .cmd_data  (cmd_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(m_tuser),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_full  (out_full),
    .out_last  (m_tlast)
  );

  assign m_tdata = OUT_TW'({out_full, out_empty, out_data});

endmodule

// ===== hdl/lcq_front.sv =====
// lcq_front: input side, decodes func and holds commands in a two-entry queue
// depends on lcq_pkg

module lcq_front import lcq_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output op_t                   cmd_op,
  output logic [DATA_WIDTH-1:0] cmd_data
);

  op_t                  op_mem [2];
  logic [DATA_WIDTH-1:0] data_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 pop;
  op_t                  op_dec;

  always_comb begin
    case (func_t'(in_func))
      FUNC_INSERT:  op_dec = OP_INSERT;
      FUNC_DELETE:  op_dec = OP_DELETE;
      FUNC_DISPLAY: op_dec = OP_DISPLAY;
      default:      op_dec = OP_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_op    = op_mem[rd_ptr];
  assign cmd_data  = data_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr]   <= op_dec;
      data_mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/lcq_back.sv =====
// lcq_back: queue store, head and tail state, command sequencer and result register
// depends on lcq_pkg

module lcq_back import lcq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  op_t                   cmd_op,
  input  logic [DATA_WIDTH-1:0] cmd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic                  out_empty,
  output logic                  out_full,
  output logic                  out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = (IW + 1 > LIMIT_W) ? IW + 1 : LIMIT_W;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] i,
                                             input logic [CW-1:0] lim);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= lim) ? '0 : n[IW-1:0];
  endfunction

  function automatic logic full_fn(input logic [IW-1:0] h, input logic [IW-1:0] t,
                                   input logic e, input logic circ,
                                   input logic [CW-1:0] lim);
    if (e) return 1'b0;
    if (circ) return step_idx(t, lim) == h;
    return CW'(t) >= (lim - CW'(1));
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  state_t          state, state_next;
  logic [IW-1:0]   head, head_next;
  logic [IW-1:0]   tail, tail_next;
  logic            empty, empty_next;
  logic [IW-1:0]   idx, idx_next;
  logic [CW-1:0]   cnt, cnt_next;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic                  re;
  logic [IW-1:0]         raddr;
  logic                  out_free;
  logic                  load;
  status_t               ld_status;
  logic [DATA_WIDTH-1:0] ld_data;
  logic                  ld_last;
  logic [CW-1:0]         lim;
  logic [CW-1:0]         lim_raw;
  logic                  full_cur;
  logic                  disp_end;
  logic [IW-1:0]         step_tmp;

  // effective limit: zero acts as one, above depth acts as depth
  assign lim_raw = CW'(cfg.queue_limit);
  always_comb begin
    if (lim_raw == '0) lim = CW'(1);
    else if (lim_raw > CW'(DEPTH)) lim = CW'(DEPTH);
    else lim = lim_raw;
  end

  assign full_cur = full_fn(head, tail, empty, cfg.circular_mode, lim);
  assign out_free = !out_valid || out_ready;
  assign disp_end = (idx == tail) || ((cnt + CW'(1)) >= lim);

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    idx_next   = idx;
    cnt_next   = cnt;
    cmd_ready  = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    re         = 1'b0;
    raddr      = head;
    load       = 1'b0;
    ld_status  = STAT_OK;
    ld_data    = '0;
    ld_last    = 1'b1;
    step_tmp   = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd_op)
            OP_INSERT: begin
              if (empty) begin
                we         = 1'b1;
                waddr      = '0;
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                load       = 1'b1;
              end else if (full_cur) begin
                load      = 1'b1;
                ld_status = STAT_OVERFLOW;
              end else begin
                step_tmp  = step_idx(tail, lim);
                we        = 1'b1;
                waddr     = step_tmp;
                tail_next = step_tmp;
                load      = 1'b1;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = STAT_UNDERFLOW;
              end else begin
                re         = 1'b1;
                raddr      = head;
                state_next = ST_DELETE;
              end
            end
            OP_DISPLAY: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = STAT_UNDERFLOW;
              end else begin
                re         = 1'b1;
                raddr      = head;
                idx_next   = head;
                cnt_next   = '0;
                state_next = ST_DISPLAY;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_DELETE: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = rd_data;
          if (head == tail) begin
            empty_next = 1'b1;
            head_next  = '0;
            tail_next  = '0;
          end else begin
            head_next = step_idx(head, lim);
          end
          state_next = ST_IDLE;
        end
      end
      ST_DISPLAY: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = rd_data;
          ld_last = disp_end;
          if (disp_end) begin
            state_next = ST_IDLE;
          end else begin
            step_tmp = step_idx(idx, lim);
            re       = 1'b1;
            raddr    = step_tmp;
            idx_next = step_tmp;
            cnt_next = cnt + CW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= cmd_data;
    if (re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // flags reflect the queue state after the step
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_data   <= ld_data;
      out_empty  <= empty_next;
      out_full   <= full_fn(head_next, tail_next, empty_next, cfg.circular_mode, lim);
      out_last   <= ld_last;
    end
  end

endmodule

// ===== verif/linear_or_circular_queue_unit_tb.sv =====
// linear_or_circular_queue_unit_tb: self-checking bench for the queue unit
// depends on lcq_pkg and linear_or_circular_queue_unit
// directed table then random phases, every result checked against a queue predictor or the row's own expectation
`timescale 1ns / 100ps

module linear_or_circular_queue_unit_tb;
  import lcq_pkg::*;

  localparam int DEPTH = 64;
  localparam int DATA_WIDTH = 32;
  localparam int S_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int M_W = ((DATA_WIDTH + 9) / 8) * 8;
  localparam int RAND_ITEMS = 100;
  localparam int CALM_ITEMS = 40;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    status_t status;
    logic [DATA_WIDTH-1:0] dout;
    logic empty;
    logic full;
    logic ends;
  } result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG,
    ROW_FILL
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    func_t func;
    logic [DATA_WIDTH-1:0] value;
    logic reg_sel;
    logic typed;
    result_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;  // data_in
  logic [1:0] s_tuser = FUNC_INSERT;  // func
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;  // data_out, is_empty, is_full
  logic [1:0] m_tuser;  // status
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // typed expectation travels with the transaction
  logic row_typed = 1'b0;
  result_t row_exp = '0;

  logic [DATA_WIDTH-1:0] q_store [DEPTH];
  int q_head = 0;
  int q_tail = 0;
  logic q_void = 1'b1;
  logic cfg_mode = MODE_RESET;
  logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;

  result_t pending_results [$];
  stim_row_t rows [$];
  result_t want;
  int fails = 0;
  int quiet_cycles = 0;
  int idle_pct = 25;
  int stall_left = 0;
  int sent = 0;
  int phase_len;
  int ins_bias;
  int del_top;
  int pick;
  func_t fsel;

  linear_or_circular_queue_unit #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic int eff_limit();
    if (cfg_limit == 0) return 1;
    if (cfg_limit > DEPTH) return DEPTH;
    return int'(cfg_limit);
  endfunction

  function automatic int next_index(int i);
    return (i + 1 >= eff_limit()) ? 0 : i + 1;
  endfunction

  function automatic logic queue_full();
    if (q_void) return 1'b0;
    if (cfg_mode) return next_index(q_tail) == q_head;
    return q_tail >= eff_limit() - 1;
  endfunction

  function automatic result_t pack_result(status_t st, logic [DATA_WIDTH-1:0] v, logic fin);
    result_t r;
    r.status = st;
    r.dout = v;
    r.empty = q_void;
    r.full = queue_full();
    r.ends = fin;
    return r;
  endfunction

  function automatic void predict_queue_op(func_t f, logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH-1:0] v;
    int lim;
    int i;
    int k;
    logic fin;
    case (f)
      FUNC_INSERT: begin
        if (q_void) begin
          q_head = 0;
          q_tail = 0;
          q_store[0] = d;
          q_void = 1'b0;
          pending_results.push_back(pack_result(STAT_OK, '0, 1'b1));
        end else if (queue_full()) begin
          pending_results.push_back(pack_result(STAT_OVERFLOW, '0, 1'b1));
        end else begin
          q_tail = next_index(q_tail) % DEPTH;
          q_store[q_tail] = d;
          pending_results.push_back(pack_result(STAT_OK, '0, 1'b1));
        end
      end
      FUNC_DELETE: begin
        if (q_void) begin
          pending_results.push_back(pack_result(STAT_UNDERFLOW, '0, 1'b1));
        end else begin
          v = q_store[q_head % DEPTH];
          if (q_head == q_tail) begin
            q_void = 1'b1;
            q_head = 0;
            q_tail = 0;
          end else begin
            q_head = next_index(q_head) % DEPTH;
          end
          pending_results.push_back(pack_result(STAT_OK, v, 1'b1));
        end
      end
      FUNC_DISPLAY: begin
        if (q_void) begin
          pending_results.push_back(pack_result(STAT_UNDERFLOW, '0, 1'b1));
        end else begin
          lim = eff_limit();
          i = q_head % DEPTH;
          k = 0;
          fin = 1'b0;
          while (!fin) begin
            fin = (i == q_tail) || (k + 1 >= lim);
            pending_results.push_back(pack_result(STAT_OK, q_store[i], fin));
            k++;
            i = next_index(i) % DEPTH;
          end
        end
      end
      default: pending_results.push_back(pack_result(STAT_OK, '0, 1'b1));
    endcase
  endfunction

  function automatic stim_row_t op_row(func_t f, logic [DATA_WIDTH-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.func = f;
    r.value = d;
    return r;
  endfunction

  function automatic stim_row_t chk_row(func_t f, logic [DATA_WIDTH-1:0] d, status_t st,
                                        logic [DATA_WIDTH-1:0] dout, logic e, logic fu);
    stim_row_t r;
    r = op_row(f, d);
    r.typed = 1'b1;
    r.exp.status = st;
    r.exp.dout = dout;
    r.exp.empty = e;
    r.exp.full = fu;
    r.exp.ends = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic sel, logic [DATA_WIDTH-1:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.value = v;
    return r;
  endfunction

  function automatic stim_row_t fill_row();
    stim_row_t r;
    r = '0;
    r.kind = ROW_FILL;
    return r;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 31))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(func_t f, logic [DATA_WIDTH-1:0] d, logic typed, result_t expv);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= d;
    row_typed <= typed;
    row_exp <= expv;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic sel, logic [DATA_WIDTH-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_MODE) cfg_mode = v[0];
    else cfg_limit = v[LIMIT_W-1:0];
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 5);
    m_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            fails++;
          end
          if (m_tdata[DATA_WIDTH-1:0] !== want.dout) begin
            $error("data_out: expected %h, got %h", want.dout, m_tdata[DATA_WIDTH-1:0]);
            fails++;
          end
          if (m_tdata[DATA_WIDTH] !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, m_tdata[DATA_WIDTH]);
            fails++;
          end
          if (m_tdata[DATA_WIDTH+1] !== want.full) begin
            $error("is_full: expected %0b, got %0b", want.full, m_tdata[DATA_WIDTH+1]);
            fails++;
          end
          if (m_tlast !== want.ends) begin
            $error("last: expected %0b, got %0b", want.ends, m_tlast);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_queue_op(func_t'(s_tuser), s_tdata[DATA_WIDTH-1:0]);
        if (row_typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(row_exp);
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    // empty queue, unused code and extremes under the reset setting
    rows.push_back(chk_row(FUNC_DISPLAY, 32'h0, STAT_UNDERFLOW, 32'h0, 1'b1, 1'b0));
    rows.push_back(chk_row(FUNC_DELETE, 32'hffff_ffff, STAT_UNDERFLOW, 32'h0, 1'b1, 1'b0));
    rows.push_back(chk_row(FUNC_UNUSED, 32'h5a5a_a5a5, STAT_OK, 32'h0, 1'b1, 1'b0));
    rows.push_back(chk_row(FUNC_INSERT, 32'h8000_0000, STAT_OK, 32'h0, 1'b0, 1'b0));
    rows.push_back(chk_row(FUNC_INSERT, 32'h7fff_ffff, STAT_OK, 32'h0, 1'b0, 1'b0));
    rows.push_back(op_row(FUNC_INSERT, 32'h0));
    rows.push_back(op_row(FUNC_INSERT, 32'hffff_ffff));
    rows.push_back(op_row(FUNC_DISPLAY, 32'h0));
    rows.push_back(chk_row(FUNC_DELETE, 32'h0, STAT_OK, 32'h8000_0000, 1'b0, 1'b0));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    rows.push_back(fill_row());
    // single slot, then a zero limit
    rows.push_back(cfg_row(REG_LIMIT, 32'd1));
    rows.push_back(chk_row(FUNC_INSERT, 32'h1234_5678, STAT_OK, 32'h0, 1'b0, 1'b1));
    rows.push_back(chk_row(FUNC_INSERT, 32'h1111_1111, STAT_OVERFLOW, 32'h0, 1'b0, 1'b1));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    rows.push_back(cfg_row(REG_LIMIT, 32'd0));
    rows.push_back(op_row(FUNC_INSERT, 32'hdead_beef));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    // linear queue of three
    rows.push_back(cfg_row(REG_MODE, 32'd0));
    rows.push_back(cfg_row(REG_LIMIT, 32'd3));
    rows.push_back(op_row(FUNC_INSERT, 32'h0000_0001));
    rows.push_back(op_row(FUNC_INSERT, 32'h0000_0002));
    rows.push_back(op_row(FUNC_INSERT, 32'h0000_0003));
    rows.push_back(chk_row(FUNC_INSERT, 32'h0000_0004, STAT_OVERFLOW, 32'h0, 1'b0, 1'b1));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    rows.push_back(op_row(FUNC_DELETE, 32'h0));
    // oversized limit, then mode and limit change with entries held
    rows.push_back(cfg_row(REG_LIMIT, 32'd127));
    rows.push_back(op_row(FUNC_INSERT, 32'hcafe_f00d));
    rows.push_back(op_row(FUNC_INSERT, 32'h0bad_0bad));
    rows.push_back(cfg_row(REG_MODE, 32'd1));
    rows.push_back(cfg_row(REG_LIMIT, 32'd1));
    rows.push_back(op_row(FUNC_DISPLAY, 32'h0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      case (rows[r].kind)
        ROW_ITEM: send_item(rows[r].func, rows[r].value, rows[r].typed, rows[r].exp);
        ROW_CFG: begin
          settle();
          apb_write(rows[r].reg_sel, rows[r].value);
        end
        default: begin
          // write every slot once so later walks never touch an unwritten word
          repeat (DEPTH) send_item(FUNC_INSERT, rand_word(), 1'b0, '0);
          send_item(FUNC_INSERT, rand_word(), 1'b0, '0);
          repeat (DEPTH) send_item(FUNC_DELETE, rand_word(), 1'b0, '0);
        end
      endcase
    end

    while (sent < RAND_ITEMS) begin
      settle();
      if (sent >= RAND_ITEMS - CALM_ITEMS) idle_pct = 0;
      else idle_pct = 20 * $urandom_range(0, 2);
      apb_write(REG_MODE, $urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) apb_write(REG_LIMIT, $urandom_range(1, 8));
      else if (pick < 8) apb_write(REG_LIMIT, $urandom_range(9, 63));
      else if (pick == 8) apb_write(REG_LIMIT, 64);
      else if ($urandom_range(0, 1) == 0) apb_write(REG_LIMIT, 0);
      else apb_write(REG_LIMIT, $urandom_range(65, 127));
      phase_len = $urandom_range(15, 35);
      ins_bias = $urandom_range(30, 75);
      del_top = ins_bias + (100 - ins_bias) * 65 / 100;
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_bias) fsel = FUNC_INSERT;
        else if (pick < del_top) fsel = FUNC_DELETE;
        else if (pick < 97) fsel = FUNC_DISPLAY;
        else fsel = FUNC_UNUSED;
        send_item(fsel, rand_word(), 1'b0, '0);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lcq_pkg.sv
hdl/lcq_front.sv
hdl/lcq_back.sv
hdl/linear_or_circular_queue_unit.sv
verif/linear_or_circular_queue_unit_tb.sv
